// File: rtl/core/raid6_degraded_stripe_map_assert.svh
// assertion macros for the stripe map checker
`ifndef RAID6_DEGRADED_STRIPE_MAP_ASSERT_SVH
`define RAID6_DEGRADED_STRIPE_MAP_ASSERT_SVH

// condition and consequence in the same cycle
`define RDSM_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("stripe map check failed");

// consequence in the cycle after the condition
`define RDSM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("stripe map check failed");

`endif

// File: rtl/core/rdsm_pkg.sv
package rdsm_pkg;

	localparam int MAX_DISKS_DEF = 32;
	localparam int MIN_DISKS     = 4;
	localparam int SYNDROMES     = 2;
	localparam int RESERVED_ROW  = 3;

	localparam int BLK_W   = 40;
	localparam int COL_W   = 5;
	localparam int SEC_W   = 48;
	localparam int DEV_W   = 5;
	localparam int DCNT_W  = 6;
	localparam int CHUNK_W = 17;

	// bits of quotient resolved per divider stage
	localparam int DIV_STEP = 8;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DISK_COUNT      = 3'd0,
		CFG_CHUNK_SECTORS   = 3'd1,
		CFG_DEVICE_SECTORS  = 3'd2,
		CFG_SEQUENTIAL_MODE = 3'd3,
		CFG_FAILED_MEMBER   = 3'd4
	} cfg_reg_t;

	localparam logic [DCNT_W-1:0]  RST_DISK_COUNT    = 6'd4;
	localparam logic [CHUNK_W-1:0] RST_CHUNK_SECTORS = 17'd8;
	localparam logic [DEV_W-1:0]   RST_FAILED_MEMBER = 5'd1;

endpackage

// File: rtl/core/rdsm_div_pipe.sv
module rdsm_div_pipe #(
	parameter int NW = 48,
	parameter int DW = 6,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_vld,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] side_in,
	output logic          out_vld,
	output logic [NW-1:0] quo,
	output logic [DW-1:0] rem,
	output logic [SW-1:0] side_out
);

	localparam int Step = rdsm_pkg::DIV_STEP;
	localparam int NS   = (NW + Step - 1) / Step;

	logic [NS:0]   vld_s;
	logic [DW-1:0] rem_s  [0:NS];
	logic [NW-1:0] nq_s   [0:NS];
	logic [DW-1:0] den_s  [0:NS];
	logic [SW-1:0] side_s [0:NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NS-1:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= '0;
			nq_s[0]   <= num;
			den_s[0]  <= den;
			side_s[0] <= side_in;
		end
	end

	for (genvar k = 0; k < NS; k++) begin : g_stage
		logic [DW-1:0] r_c;
		logic [NW-1:0] q_c;

		// restoring division, numerator shifts out as quotient shifts in
		always_comb begin
			logic [DW:0] t;
			t   = '0;
			r_c = rem_s[k];
			q_c = nq_s[k];
			for (int j = 0; j < Step; j++) begin
				if (k * Step + j < NW) begin
					t   = {r_c, q_c[NW-1]};
					q_c = {q_c[NW-2:0], 1'b0};
					if (t >= {1'b0, den_s[k]}) begin
						t      = t - {1'b0, den_s[k]};
						q_c[0] = 1'b1;
					end
					r_c = t[DW-1:0];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= r_c;
				nq_s[k+1]   <= q_c;
				den_s[k+1]  <= den_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_vld  = vld_s[NS];
	assign quo      = nq_s[NS];
	assign rem      = rem_s[NS];
	assign side_out = side_s[NS];

endmodule

// File: rtl/core/raid6_degraded_stripe_map.sv
// two-syndrome rotating-parity stripe mapper with one degraded member
//
// cfg channel: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is always
//   high and the register is written at the handshake; write only while idle
// in channel: in_valid/in_ready carries one request word (block_index, column,
//   sector_in); out channel: out_valid/out_ready carries one result word per request
// throughput: one word per cycle while the receiver keeps out_ready high
// pipeline: one input register, seven long dividers of ceil(w/8)+1 stages each
//   (w = dividend width), two multiply stages and the output register; most
//   of the stages lie in the dividers
// stall: the whole pipe holds while a result waits with out_ready low, and
//   in_ready drops in that same cycle; nothing is lost or repeated
// reset: arst_n clears all valid bits and loads the register defaults
//   (4 disks, 8-sector chunks, zero device length, sequential off, disk 1 degraded)
module raid6_degraded_stripe_map #(
	parameter int MAX_DISKS = rdsm_pkg::MAX_DISKS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [rdsm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rdsm_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [rdsm_pkg::BLK_W-1:0]       block_index,
	input  logic [rdsm_pkg::COL_W-1:0]       column,
	input  logic [rdsm_pkg::SEC_W-1:0]       sector_in,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [rdsm_pkg::DEV_W-1:0]       data_device,
	output logic [rdsm_pkg::SEC_W-1:0]       data_sector,
	output logic [rdsm_pkg::DEV_W-1:0]       p_device,
	output logic [rdsm_pkg::SEC_W-1:0]       p_sector,
	output logic [rdsm_pkg::DEV_W-1:0]       q_device,
	output logic [rdsm_pkg::SEC_W-1:0]       q_sector,
	output logic [rdsm_pkg::SEC_W-1:0]       row_start_sector,
	output logic                             last_in_stripe
);

	localparam int DCW  = $clog2(MAX_DISKS + 1);
	localparam int DBW  = rdsm_pkg::BLK_W + DCW + 1;
	localparam int PW   = DBW + 1;
	localparam int SW   = rdsm_pkg::SEC_W;
	localparam int CKW  = rdsm_pkg::CHUNK_W;
	localparam int HALF = SW / 2;
	localparam int HI_W = SW - HALF;

	// everything one request carries down the pipe
	typedef struct packed {
		logic [DBW-1:0] dblk;
		logic [SW-1:0]  sec;
		logic [DBW-1:0] lane;
		logic [DCW-1:0] slot;
		logic [DCW-1:0] y;
		logic [1:0]     gap;
		logic [PW-1:0]  posq;
		logic [DCW-1:0] ddev;
		logic [CKW-1:0] off;
		logic [PW-1:0]  row;
		logic [DCW-1:0] dv;
		logic [SW-1:0]  zone;
	} item_t;

	localparam int IW = $bits(item_t);

	// configuration registers
	logic [rdsm_pkg::DCNT_W-1:0] disk_count_q;
	logic [CKW-1:0]              chunk_sectors_q;
	logic [SW-1:0]               device_sectors_q;
	logic                        sequential_mode_q;
	logic [rdsm_pkg::DEV_W-1:0]  failed_member_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disk_count_q      <= rdsm_pkg::RST_DISK_COUNT;
			chunk_sectors_q   <= rdsm_pkg::RST_CHUNK_SECTORS;
			device_sectors_q  <= '0;
			sequential_mode_q <= 1'b0;
			failed_member_q   <= rdsm_pkg::RST_FAILED_MEMBER;
		end else if (cfg_valid) begin
			case (cfg_index)
				rdsm_pkg::CFG_DISK_COUNT: begin
					disk_count_q <= cfg_data[rdsm_pkg::DCNT_W-1:0];
				end
				rdsm_pkg::CFG_CHUNK_SECTORS: begin
					chunk_sectors_q <= cfg_data[CKW-1:0];
				end
				rdsm_pkg::CFG_DEVICE_SECTORS: begin
					device_sectors_q <= cfg_data[SW-1:0];
				end
				rdsm_pkg::CFG_SEQUENTIAL_MODE: begin
					sequential_mode_q <= cfg_data[0];
				end
				rdsm_pkg::CFG_FAILED_MEMBER: begin
					failed_member_q <= cfg_data[rdsm_pkg::DEV_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// effective disk count and chunk size
	logic [6:0]     dc7;
	logic [DCW-1:0] d_eff, d_m1, d_m2, d_m3;
	logic [CKW-1:0] chunk_eff;

	always_comb begin
		dc7 = 7'(disk_count_q);
		if (dc7 < 7'(rdsm_pkg::MIN_DISKS)) begin
			d_eff = DCW'(rdsm_pkg::MIN_DISKS);
		end else if (dc7 > 7'(MAX_DISKS)) begin
			d_eff = DCW'(MAX_DISKS);
		end else begin
			d_eff = DCW'(dc7);
		end
	end

	assign d_m1      = d_eff - DCW'(1);
	assign d_m2      = d_eff - DCW'(rdsm_pkg::SYNDROMES);
	assign d_m3      = d_eff - DCW'(rdsm_pkg::RESERVED_ROW);
	assign chunk_eff = (chunk_sectors_q == '0) ? CKW'(1) : chunk_sectors_q;

	// global advance: the pipe moves unless the output word is stuck
	logic en;
	logic vld_s1, vld_s2, vld_s3, vld_s4;

	assign en       = !vld_s4 || out_ready;
	assign in_ready = en;

	// stage 1: logical data block number
	item_t it_in, it_s1;

	always_comb begin
		it_in      = '0;
		it_in.dblk = DBW'(column) + DBW'(block_index) * DBW'(d_eff);
		it_in.sec  = sector_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s1 <= it_in;
		end
	end

	// lane and slot within the lane
	logic           v1;
	logic [DBW-1:0] q1;
	logic [DCW-1:0] r1;
	logic [IW-1:0]  sd1;
	item_t          it1;

	rdsm_div_pipe #(.NW(DBW), .DW(DCW), .SW(IW)) u_div_lane (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s1),
		.num(it_s1.dblk), .den(d_m2), .side_in(it_s1),
		.out_vld(v1), .quo(q1), .rem(r1), .side_out(sd1)
	);

	always_comb begin
		it1      = item_t'(sd1);
		it1.lane = q1;
		it1.slot = r1;
	end

	// rotation index of the lane within its square
	logic           v2;
	logic [DCW-1:0] r2;
	logic [IW-1:0]  sd2;
	item_t          it2;
	logic [DCW:0]   slot_y;
	logic [PW-1:0]  pos;

	rdsm_div_pipe #(.NW(DBW), .DW(DCW), .SW(IW)) u_div_rot (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(v1),
		.num(it1.lane), .den(d_eff), .side_in(it1),
		.out_vld(v2), .quo(), .rem(r2), .side_out(sd2)
	);

	// syndrome slots skipped before the data position
	always_comb begin
		it2    = item_t'(sd2);
		it2.y  = r2;
		slot_y = {1'b0, it2.slot} + {1'b0, r2};
		it2.gap = 2'd2;
		if (r2 == d_m1) begin
			it2.gap = 2'd1;
		end
		if (slot_y < {1'b0, d_m2}) begin
			it2.gap = 2'd0;
		end
		pos = PW'(it2.dblk) + PW'(it2.gap) + {it2.lane, 1'b0};
	end

	// physical chunk number and data device
	logic           v3;
	logic [PW-1:0]  q3;
	logic [DCW-1:0] r3;
	logic [IW-1:0]  sd3;
	item_t          it3;

	rdsm_div_pipe #(.NW(PW), .DW(DCW), .SW(IW)) u_div_pos (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(v2),
		.num(pos), .den(d_eff), .side_in(it2),
		.out_vld(v3), .quo(q3), .rem(r3), .side_out(sd3)
	);

	always_comb begin
		it3      = item_t'(sd3);
		it3.posq = q3;
		it3.ddev = r3;
	end

	// offset inside the chunk
	logic           v4;
	logic [CKW-1:0] r4;
	logic [IW-1:0]  sd4;
	item_t          it4;

	rdsm_div_pipe #(.NW(SW), .DW(CKW), .SW(IW)) u_div_off (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(v3),
		.num(it3.sec), .den(chunk_eff), .side_in(it3),
		.out_vld(v4), .quo(), .rem(r4), .side_out(sd4)
	);

	always_comb begin
		it4     = item_t'(sd4);
		it4.off = r4;
	end

	// spare zone row and device
	logic           v5;
	logic [PW-1:0]  q5;
	logic [DCW-1:0] r5;
	logic [IW-1:0]  sd5;
	item_t          it5;

	rdsm_div_pipe #(.NW(PW), .DW(DCW), .SW(IW)) u_div_spare (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(v4),
		.num(it4.posq), .den(d_m1), .side_in(it4),
		.out_vld(v5), .quo(q5), .rem(r5), .side_out(sd5)
	);

	always_comb begin
		it5     = item_t'(sd5);
		it5.row = q5;
		it5.dv  = r5;
	end

	// spare zone base: device length over the disk count minus three, then over the disk count
	logic          v6;
	logic [SW-1:0] q6;
	logic [IW-1:0] sd6;
	item_t         it6;

	rdsm_div_pipe #(.NW(SW), .DW(DCW), .SW(IW)) u_div_zone_a (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(v5),
		.num(device_sectors_q), .den(d_m3), .side_in(it5),
		.out_vld(v6), .quo(q6), .rem(), .side_out(sd6)
	);

	always_comb begin
		it6      = item_t'(sd6);
		it6.zone = q6;
	end

	logic          v7;
	logic [SW-1:0] q7;
	logic [IW-1:0] sd7;
	item_t         it7;

	rdsm_div_pipe #(.NW(SW), .DW(DCW), .SW(IW)) u_div_zone_b (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(v6),
		.num(it6.zone), .den(d_eff), .side_in(it6),
		.out_vld(v7), .quo(q7), .rem(), .side_out(sd7)
	);

	always_comb begin
		it7      = item_t'(sd7);
		it7.zone = q7;
	end

	// stage 2: split 48 x 17 products into two halves
	logic [SW-1:0]       posq48, row48;
	logic [HI_W+CKW-1:0] st_hi_full, rw_hi_full;
	logic [HALF+CKW-1:0] st_lo_s2, rw_lo_s2;
	logic [HI_W-1:0]     st_hi_s2, rw_hi_s2;
	item_t               it_s2;

	assign posq48     = SW'(it7.posq);
	assign row48      = SW'(it7.row);
	assign st_hi_full = posq48[SW-1:HALF] * chunk_eff;
	assign rw_hi_full = row48[SW-1:HALF] * chunk_eff;

	always_ff @(posedge clk) begin
		if (en) begin
			st_lo_s2 <= posq48[HALF-1:0] * chunk_eff;
			rw_lo_s2 <= row48[HALF-1:0] * chunk_eff;
			st_hi_s2 <= st_hi_full[HI_W-1:0];
			rw_hi_s2 <= rw_hi_full[HI_W-1:0];
			it_s2    <= it7;
		end
	end

	// stage 3: row start and spare sector, wrapped at 48 bits
	logic [SW-1:0] start_s3, rsec_s3;
	item_t         it_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			start_s3 <= SW'(st_lo_s2) + {st_hi_s2, {HALF{1'b0}}};
			rsec_s3  <= it_s2.zone + SW'(rw_lo_s2) + {rw_hi_s2, {HALF{1'b0}}};
			it_s3    <= it_s2;
		end
	end

	// stage 4 (output word): syndrome devices and degraded redirect
	logic [DCW-1:0] qdev_c, pdev_c, ddev_c, dv_adj;
	logic [SW-1:0]  dsec_c, psec_c, qsec_c;
	logic           last_c;
	logic [6:0]     deg7;

	always_comb begin
		deg7   = 7'(failed_member_q);
		qdev_c = d_m1 - it_s3.y;
		pdev_c = (it_s3.y < d_m1) ? qdev_c - DCW'(1) : d_m1;
		ddev_c = it_s3.ddev;
		dv_adj = (7'(it_s3.dv) >= deg7) ? it_s3.dv + DCW'(1) : it_s3.dv;
		dsec_c = start_s3 + SW'(it_s3.off);
		psec_c = start_s3;
		qsec_c = start_s3;
		// last data chunk sits just before the syndromes it skips
		last_c = sequential_mode_q &&
			(({1'b0, it_s3.ddev} + (DCW + 1)'(2'd2 - it_s3.gap)) == {1'b0, d_m1});
		// first of data, p, q on the degraded disk moves to the spare zone
		if (7'(ddev_c) == deg7) begin
			ddev_c = dv_adj;
			dsec_c = rsec_s3 + SW'(it_s3.off);
		end else if (7'(pdev_c) == deg7) begin
			pdev_c = dv_adj;
			psec_c = rsec_s3;
		end else if (7'(qdev_c) == deg7) begin
			qdev_c = dv_adj;
			qsec_c = rsec_s3;
		end
	end

	logic [rdsm_pkg::DEV_W-1:0] ddev_s4, pdev_s4, qdev_s4;
	logic [SW-1:0]              dsec_s4, psec_s4, qsec_s4, start_s4;
	logic                       last_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s2 <= v7;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ddev_s4  <= rdsm_pkg::DEV_W'(ddev_c);
			pdev_s4  <= rdsm_pkg::DEV_W'(pdev_c);
			qdev_s4  <= rdsm_pkg::DEV_W'(qdev_c);
			dsec_s4  <= dsec_c;
			psec_s4  <= psec_c;
			qsec_s4  <= qsec_c;
			start_s4 <= start_s3;
			last_s4  <= last_c;
		end
	end

	assign out_valid        = vld_s4;
	assign data_device      = ddev_s4;
	assign data_sector      = dsec_s4;
	assign p_device         = pdev_s4;
	assign p_sector         = psec_s4;
	assign q_device         = qdev_s4;
	assign q_sector         = qsec_s4;
	assign row_start_sector = start_s4;
	assign last_in_stripe   = last_s4;

endmodule

// File: rtl/core/raid6_degraded_stripe_map_chk.sv
`include "raid6_degraded_stripe_map_assert.svh"

module raid6_degraded_stripe_map_chk (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       cfg_valid,
	input logic                       cfg_ready,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [rdsm_pkg::DEV_W-1:0] data_device,
	input logic [rdsm_pkg::SEC_W-1:0] data_sector
);

	// a stalled result word holds
	`RDSM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(data_sector))
	`RDSM_ASSERT_NEXT(a_dev_hold, out_valid && !out_ready, $stable(data_device))

	// input side follows the output stall in the same cycle
	`RDSM_ASSERT_SAME(a_in_ready, 1'b1, in_ready == (!out_valid || out_ready))

	// register writes are never held off
	`RDSM_ASSERT_SAME(a_cfg_ready, cfg_valid, cfg_ready)

endmodule

bind raid6_degraded_stripe_map raid6_degraded_stripe_map_chk u_chk (.*);

// File: sim/raid6_degraded_stripe_map_test.sv
module raid6_degraded_stripe_map_test;

	localparam logic [rdsm_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;
	localparam longint unsigned M48 = 64'hFFFF_FFFF_FFFF;
	localparam longint unsigned M40 = 64'hFF_FFFF_FFFF;
	localparam int SETTLE_CYCLES = 60;

	typedef struct {
		logic [rdsm_pkg::DEV_W-1:0] data_device;
		logic [rdsm_pkg::SEC_W-1:0] data_sector;
		logic [rdsm_pkg::DEV_W-1:0] p_device;
		logic [rdsm_pkg::SEC_W-1:0] p_sector;
		logic [rdsm_pkg::DEV_W-1:0] q_device;
		logic [rdsm_pkg::SEC_W-1:0] q_sector;
		logic [rdsm_pkg::SEC_W-1:0] row_start_sector;
		logic                       last_in_stripe;
	} map_word_t;

	// predicts the physical placement of each accepted request and holds it until it comes out
	class stripe_map_board;
		logic [rdsm_pkg::DCNT_W-1:0]  disk_count;
		logic [rdsm_pkg::CHUNK_W-1:0] chunk_sectors;
		logic [rdsm_pkg::SEC_W-1:0]   device_sectors;
		logic                         sequential_mode;
		logic [rdsm_pkg::DEV_W-1:0]   failed_member;
		map_word_t                    placements[$];
		int                           mismatches;
		int                           checked;

		function new();
			disk_count = rdsm_pkg::RST_DISK_COUNT;
			chunk_sectors = rdsm_pkg::RST_CHUNK_SECTORS;
			device_sectors = '0;
			sequential_mode = 1'b0;
			failed_member = rdsm_pkg::RST_FAILED_MEMBER;
			mismatches = 0;
			checked = 0;
		endfunction

		function void write_reg(logic [rdsm_pkg::CFG_IDX_W-1:0] idx,
				logic [rdsm_pkg::CFG_DATA_W-1:0] val);
			case (idx)
				rdsm_pkg::CFG_DISK_COUNT: disk_count = val[rdsm_pkg::DCNT_W-1:0];
				rdsm_pkg::CFG_CHUNK_SECTORS: chunk_sectors = val[rdsm_pkg::CHUNK_W-1:0];
				rdsm_pkg::CFG_DEVICE_SECTORS: device_sectors = val[rdsm_pkg::SEC_W-1:0];
				rdsm_pkg::CFG_SEQUENTIAL_MODE: sequential_mode = val[0];
				rdsm_pkg::CFG_FAILED_MEMBER: failed_member = val[rdsm_pkg::DEV_W-1:0];
				default: ;
			endcase
		endfunction

		// spare-zone place of physical chunk number pos
		function void spare(longint unsigned pos, longint unsigned d, longint unsigned chunk,
				output longint unsigned dev, output longint unsigned sec);
			longint unsigned dv, row, zone;
			dv = pos % (d - 1);
			row = pos / (d - 1);
			if (dv >= failed_member) dv++;
			zone = (device_sectors / (d - rdsm_pkg::RESERVED_ROW)) / d;
			dev = dv;
			sec = zone + row * chunk;
		endfunction

		function void note_request(logic [rdsm_pkg::BLK_W-1:0] blk_i,
				logic [rdsm_pkg::COL_W-1:0] col_i, logic [rdsm_pkg::SEC_W-1:0] sec_i);
			longint unsigned d, chunk, width, dblk, lane, slot, y, gap, pos;
			longint unsigned ddev, start, off, dsec, pdev, psec, qdev, qsec, rdev, rsec;
			map_word_t w;
			d = disk_count;
			if (d < rdsm_pkg::MIN_DISKS) d = rdsm_pkg::MIN_DISKS;
			if (d > rdsm_pkg::MAX_DISKS_DEF) d = rdsm_pkg::MAX_DISKS_DEF;
			chunk = (chunk_sectors == 0) ? 1 : chunk_sectors;
			width = d - rdsm_pkg::SYNDROMES;
			dblk = longint'(col_i) + longint'(blk_i) * d;
			lane = dblk / width;
			slot = dblk % width;
			y = lane % d;
			gap = 2;
			if (y == d - 1) gap = 1;
			if (slot + y < width) gap = 0;
			pos = dblk + gap + rdsm_pkg::SYNDROMES * lane;
			ddev = pos % d;
			pos = pos / d;
			w.last_in_stripe = sequential_mode && (ddev + (2 - gap) == d - 1);
			off = longint'(sec_i) % chunk;
			start = pos * chunk;
			dsec = start + off;
			psec = start;
			qsec = start;
			qdev = d - 1 - y;
			pdev = (y < d - 1) ? qdev - 1 : d - 1;
			// only the first of data, p, q on the degraded member moves
			if (ddev == failed_member) begin
				spare(pos, d, chunk, rdev, rsec);
				ddev = rdev;
				dsec = rsec + off;
			end else if (pdev == failed_member) begin
				spare(pos, d, chunk, rdev, rsec);
				pdev = rdev;
				psec = rsec;
			end else if (qdev == failed_member) begin
				spare(pos, d, chunk, rdev, rsec);
				qdev = rdev;
				qsec = rsec;
			end
			w.data_device = ddev[rdsm_pkg::DEV_W-1:0];
			w.data_sector = rdsm_pkg::SEC_W'(dsec);
			w.p_device = pdev[rdsm_pkg::DEV_W-1:0];
			w.p_sector = rdsm_pkg::SEC_W'(psec);
			w.q_device = qdev[rdsm_pkg::DEV_W-1:0];
			w.q_sector = rdsm_pkg::SEC_W'(qsec);
			w.row_start_sector = rdsm_pkg::SEC_W'(start);
			placements.push_back(w);
		endfunction

		task report(string what, longint unsigned got, longint unsigned want);
			$display("mismatch on %s: got %0h, expected %0h", what, got, want);
			mismatches++;
		endtask

		task check_word(map_word_t got);
			map_word_t e;
			if (placements.size() == 0) begin
				report("unexpected word", 1, 0);
				return;
			end
			e = placements.pop_front();
			checked++;
			if (got.data_device !== e.data_device)
				report("data_device", 64'(got.data_device), 64'(e.data_device));
			if (got.data_sector !== e.data_sector)
				report("data_sector", 64'(got.data_sector), 64'(e.data_sector));
			if (got.p_device !== e.p_device)
				report("p_device", 64'(got.p_device), 64'(e.p_device));
			if (got.p_sector !== e.p_sector)
				report("p_sector", 64'(got.p_sector), 64'(e.p_sector));
			if (got.q_device !== e.q_device)
				report("q_device", 64'(got.q_device), 64'(e.q_device));
			if (got.q_sector !== e.q_sector)
				report("q_sector", 64'(got.q_sector), 64'(e.q_sector));
			if (got.row_start_sector !== e.row_start_sector)
				report("row_start_sector", 64'(got.row_start_sector),
					64'(e.row_start_sector));
			if (got.last_in_stripe !== e.last_in_stripe)
				report("last_in_stripe", 64'(got.last_in_stripe), 64'(e.last_in_stripe));
		endtask
	endclass

	logic clk, arst_n;
	logic cfg_valid, cfg_ready;
	logic [rdsm_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [rdsm_pkg::CFG_DATA_W-1:0] cfg_data;
	logic in_valid, in_ready;
	logic [rdsm_pkg::BLK_W-1:0] block_index;
	logic [rdsm_pkg::COL_W-1:0] column;
	logic [rdsm_pkg::SEC_W-1:0] sector_in;
	logic out_valid, out_ready;
	logic [rdsm_pkg::DEV_W-1:0] data_device, p_device, q_device;
	logic [rdsm_pkg::SEC_W-1:0] data_sector, p_sector, q_sector, row_start_sector;
	logic last_in_stripe;

	stripe_map_board board;
	int calm_cycles = 0;   // receiver keeps ready high while nonzero
	int hold_cycles = 0;   // receiver keeps ready low while nonzero
	int sender_calm = 0;   // sender offers back to back while nonzero
	int configs_run = 0;

	raid6_degraded_stripe_map dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// result side: random backpressure, a calm stretch, and a long hold-off on request
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ready <= 1'b0;
		end else if (calm_cycles > 0) begin
			calm_cycles <= calm_cycles - 1;
			out_ready <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(99) >= 21);
		end
	end

	// every accepted result word is checked against the oldest prediction
	always @(posedge clk) begin
		map_word_t w;
		if (arst_n && out_valid && out_ready) begin
			w.data_device = data_device;
			w.data_sector = data_sector;
			w.p_device = p_device;
			w.p_sector = p_sector;
			w.q_device = q_device;
			w.q_sector = q_sector;
			w.row_start_sector = row_start_sector;
			w.last_in_stripe = last_in_stripe;
			board.check_word(w);
		end
	end

	// register write at the cfg handshake, only while the pipe is empty
	task automatic write_reg(logic [rdsm_pkg::CFG_IDX_W-1:0] idx,
			logic [rdsm_pkg::CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		board.write_reg(idx, val);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// stop offering, wait for every prediction to come out, then let the pipe settle
	task automatic drain();
		in_valid <= 1'b0;
		while (board.placements.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic setup(int dc, int cs, longint unsigned ds, bit seq, int dd);
		drain();
		write_reg(rdsm_pkg::CFG_DISK_COUNT, rdsm_pkg::CFG_DATA_W'(dc));
		write_reg(rdsm_pkg::CFG_CHUNK_SECTORS, rdsm_pkg::CFG_DATA_W'(cs));
		write_reg(rdsm_pkg::CFG_DEVICE_SECTORS, rdsm_pkg::CFG_DATA_W'(ds));
		write_reg(rdsm_pkg::CFG_SEQUENTIAL_MODE, rdsm_pkg::CFG_DATA_W'(seq));
		write_reg(rdsm_pkg::CFG_FAILED_MEMBER, rdsm_pkg::CFG_DATA_W'(dd));
		configs_run++;
	endtask

	// offer one request word, keep it until accepted, then maybe idle
	task automatic send_request(logic [rdsm_pkg::BLK_W-1:0] b, logic [rdsm_pkg::COL_W-1:0] c,
			logic [rdsm_pkg::SEC_W-1:0] s);
		in_valid <= 1'b1;
		block_index <= b;
		column <= c;
		sector_in <= s;
		do @(posedge clk); while (!in_ready);
		board.note_request(b, c, s);
		if (sender_calm > 0) begin
			sender_calm--;
		end else if ($urandom_range(99) < 27) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	function automatic logic [rdsm_pkg::SEC_W-1:0] rand48();
		return rdsm_pkg::SEC_W'({$urandom, $urandom});
	endfunction

	// one random request; columns mostly inside the member count
	task automatic random_request();
		logic [rdsm_pkg::BLK_W-1:0] b;
		logic [rdsm_pkg::COL_W-1:0] c;
		int dcl;
		dcl = board.disk_count < rdsm_pkg::MIN_DISKS ? rdsm_pkg::MIN_DISKS :
			(board.disk_count > rdsm_pkg::MAX_DISKS_DEF ? rdsm_pkg::MAX_DISKS_DEF :
			int'(board.disk_count));
		b = ($urandom_range(3) == 0) ? rdsm_pkg::BLK_W'($urandom_range(200)) :
			rdsm_pkg::BLK_W'({$urandom, $urandom});
		c = ($urandom_range(9) == 0) ? rdsm_pkg::COL_W'($urandom_range(31)) :
			rdsm_pkg::COL_W'($urandom_range(dcl - 1));
		send_request(b, c, rand48());
	endtask

	task automatic random_phase(int n);
		repeat (n) random_request();
	endtask

	initial begin
		int i;
		board = new();
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		block_index = '0;
		column = '0;
		sector_in = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// directed: field extremes at the reset settings
		send_request('0, '0, '0);
		send_request(rdsm_pkg::BLK_W'(M40), 5'd31, rdsm_pkg::SEC_W'(M48));
		send_request('0, 5'd3, 48'd7);
		send_request(40'd1, 5'd0, 48'd8);
		for (i = 0; i < 8; i++)
			send_request(rdsm_pkg::BLK_W'(i), rdsm_pkg::COL_W'(i % 4), rdsm_pkg::SEC_W'(i));
		// last-in-stripe marking, wide disks, huge chunks and device length
		setup(32, 65536, M48, 1, 31);
		send_request(rdsm_pkg::BLK_W'(M40), 5'd31, rdsm_pkg::SEC_W'(M48));
		send_request('0, '0, 48'd65535);
		for (i = 0; i < 4; i++)
			send_request(rdsm_pkg::BLK_W'(i * 31), rdsm_pkg::COL_W'(29 + (i % 3)), rand48());
		// out-of-range disk counts saturate, zero chunk, degraded disk outside the members
		setup(0, 0, 48'd1000, 0, 20);
		send_request(40'd5, 5'd2, rand48());
		setup(63, 1, 48'd12345, 1, 0);
		send_request(40'd9, 5'd31, rand48());
		// unknown register index must be ignored
		drain();
		write_reg(CFG_UNUSED_IDX, rdsm_pkg::CFG_DATA_W'(M48));
		send_request(40'd17, 5'd4, rand48());

		// random phases over several settings
		setup(4, 8, 48'd100000, 1, 1);
		random_phase(200);
		setup(32, 65536, M48, 1, 31);
		random_phase(200);
		setup(5, 1, 48'd0, 0, 0);
		// block fills while the receiver holds off and the sender streams
		calm_cycles <= 0;
		hold_cycles <= 150;
		sender_calm = 120;
		random_phase(200);
		setup($urandom_range(4, 32), $urandom_range(1, 65536), rand48(), 1,
			$urandom_range(31));
		calm_cycles <= 300;
		sender_calm = 300;
		random_phase(300);
		for (i = 0; i < 6; i++) begin
			setup($urandom_range(4, 32), ($urandom_range(3) == 0) ? $urandom_range(65536) :
				$urandom_range(1, 64), rand48(), 1'($urandom_range(1)), $urandom_range(31));
			random_phase(70);
			// sender pauses until every result is back
			drain();
			random_phase(70);
		end

		drain();
		$display("checked %0d mapped words over %0d register settings", board.checked, configs_run);
		$display("covered saturated disk counts, zero chunks, spare-zone moves and backpressure");
		if (board.mismatches == 0 && board.placements.size() == 0)
			$display("raid6_degraded_stripe_map_test passed");
		else
			$display("raid6_degraded_stripe_map_test failed");
		$finish;
	end

	initial begin
		#(20 * 400000);
		$display("raid6_degraded_stripe_map_test failed");
		$finish;
	end

endmodule
